FILE: hw/rtl/bdpr_pkg.sv
// Shared types and constants for the debounced button press and release block.
package bdpr_pkg;

    localparam int unsigned FIELD_TIME_W = 32;
    localparam int unsigned DEBOUNCE_W   = 16;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 1'd1;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET      = 16'd50;
    localparam logic                  PRESSED_LEVEL_RESET = 1'b0;

    typedef enum logic [1:0] {
        PH_AWAIT_PRESS   = 2'd0,
        PH_PRESSED       = 2'd1,
        PH_AWAIT_RELEASE = 2'd2,
        PH_RELEASED      = 2'd3
    } t_phase;

    typedef struct packed {
        logic                    pin_level;
        logic [FIELD_TIME_W-1:0] now_ms;
        logic                    press_accept;
        logic                    release_accept;
    } t_in_item;

    typedef struct packed {
        logic                    press_event;
        logic                    release_event;
        logic [FIELD_TIME_W-1:0] held_ms;
        logic                    button_down;
        logic [FIELD_TIME_W-1:0] pressing_ms;
    } t_out_item;

endpackage

FILE: hw/rtl/bdpr_step.sv
// Combinational poll step: level change tracking, debounce check and button state update.
module bdpr_step #(
    parameter int unsigned TIME_BITS = 32
) (
    input  bdpr_pkg::t_in_item                  i_item,
    input  logic [bdpr_pkg::DEBOUNCE_W-1:0]     i_debounce_ms,
    input  logic                                i_pressed_level,
    input  bdpr_pkg::t_phase                    i_phase,
    input  logic                                i_last_pressed,
    input  logic [TIME_BITS-1:0]                i_change_time,
    input  logic [TIME_BITS-1:0]                i_press_start,
    output bdpr_pkg::t_phase                    o_phase,
    output logic                                o_last_pressed,
    output logic [TIME_BITS-1:0]                o_change_time,
    output logic [TIME_BITS-1:0]                o_press_start,
    output bdpr_pkg::t_out_item                 o_result
);

    localparam int unsigned FW = bdpr_pkg::FIELD_TIME_W;
    localparam int unsigned DW = bdpr_pkg::DEBOUNCE_W;
    localparam int unsigned CW = (TIME_BITS > DW) ? TIME_BITS : DW;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] stable_time;
    logic [TIME_BITS-1:0] press_time;
    logic [CW-1:0]        stable_cmp;
    logic [CW-1:0]        debounce_cmp;
    logic [FW-1:0]        press_time_f;
    logic                 pressed;
    logic                 stable;
    logic                 pev;
    logic                 rev;
    bdpr_pkg::t_phase     ph;

    generate
        if (TIME_BITS > FW) begin : g_wide
            assign now_t        = {{(TIME_BITS-FW){1'b0}}, i_item.now_ms};
            assign press_time_f = press_time[FW-1:0];
        end else if (TIME_BITS == FW) begin : g_same
            assign now_t        = i_item.now_ms;
            assign press_time_f = press_time;
        end else begin : g_narrow
            assign now_t        = i_item.now_ms[TIME_BITS-1:0];
            assign press_time_f = {{(FW-TIME_BITS){1'b0}}, press_time};
        end
        if (CW > TIME_BITS) begin : g_cmp_ext
            assign stable_cmp = {{(CW-TIME_BITS){1'b0}}, stable_time};
        end else begin : g_cmp_same
            assign stable_cmp = stable_time;
        end
        if (CW > DW) begin : g_deb_ext
            assign debounce_cmp = {{(CW-DW){1'b0}}, i_debounce_ms};
        end else begin : g_deb_same
            assign debounce_cmp = i_debounce_ms;
        end
    endgenerate

    assign pressed     = (i_item.pin_level == i_pressed_level);
    assign stable_time = now_t - i_change_time;
    assign stable      = (stable_cmp >= debounce_cmp);
    assign press_time  = now_t - o_press_start;

    always_comb begin
        o_phase        = i_phase;
        o_last_pressed = i_last_pressed;
        o_change_time  = i_change_time;
        o_press_start  = i_press_start;
        pev            = 1'b0;
        rev            = 1'b0;
        ph             = i_phase;
        if (pressed != i_last_pressed) begin
            o_change_time  = now_t;
            o_last_pressed = pressed;
        end else if (stable) begin
            if (ph == bdpr_pkg::PH_AWAIT_PRESS && pressed) begin
                ph            = bdpr_pkg::PH_PRESSED;
                o_press_start = now_t;
            end
            if (ph == bdpr_pkg::PH_PRESSED) begin
                if (!pressed) begin
                    ph = bdpr_pkg::PH_RELEASED;
                end else begin
                    pev = 1'b1;
                    if (i_item.press_accept) begin
                        ph = bdpr_pkg::PH_AWAIT_RELEASE;
                    end
                end
            end else begin
                if (ph == bdpr_pkg::PH_AWAIT_RELEASE && !pressed) begin
                    ph = bdpr_pkg::PH_RELEASED;
                end
                if (ph == bdpr_pkg::PH_RELEASED) begin
                    rev = 1'b1;
                    if (i_item.release_accept) begin
                        ph = bdpr_pkg::PH_AWAIT_PRESS;
                    end
                end
            end
            o_phase = ph;
        end
    end

    always_comb begin
        o_result.press_event   = pev;
        o_result.release_event = rev;
        o_result.held_ms       = rev ? press_time_f : '0;
        o_result.button_down   = (o_phase != bdpr_pkg::PH_AWAIT_PRESS);
        o_result.pressing_ms   = (o_phase != bdpr_pkg::PH_AWAIT_PRESS) ? press_time_f : '0;
    end

endmodule

FILE: hw/rtl/button_debounce_press_release_top.sv
// Top level of the debounced button block: configuration, input register, state and result register.
// Each poll passes through the input register and then the result register, which loads when free.
// Throughput: one poll per cycle unless the receiver stalls; a new poll still transfers while a
// finished result waits downstream, as long as the input register is empty.
// The step logic is two 32-bit subtractions and a compare plus the four-state update per cycle.
// Reset (synchronous, active low) empties both registers, sets awaiting press with zero times,
// and loads a debounce time of 50 ms with a pressed level of 0.
module button_debounce_press_release_top #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bdpr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bdpr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  bdpr_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output bdpr_pkg::t_out_item                 o_out_data
);

    logic [bdpr_pkg::DEBOUNCE_W-1:0] r_debounce_ms;
    logic                            r_pressed_level;

    logic                 r_in_vld;
    bdpr_pkg::t_in_item   r_in;
    logic                 r_out_vld;
    bdpr_pkg::t_out_item  r_out;

    bdpr_pkg::t_phase     r_phase;
    logic                 r_last_pressed;
    logic [TIME_BITS-1:0] r_change_time;
    logic [TIME_BITS-1:0] r_press_start;

    bdpr_pkg::t_phase     n_phase;
    logic                 n_last_pressed;
    logic [TIME_BITS-1:0] n_change_time;
    logic [TIME_BITS-1:0] n_press_start;
    bdpr_pkg::t_out_item  n_out;

    logic out_free;
    logic advance;
    logic in_take;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    bdpr_step #(
        .TIME_BITS(TIME_BITS)
    ) u_step (
        .i_item         (r_in),
        .i_debounce_ms  (r_debounce_ms),
        .i_pressed_level(r_pressed_level),
        .i_phase        (r_phase),
        .i_last_pressed (r_last_pressed),
        .i_change_time  (r_change_time),
        .i_press_start  (r_press_start),
        .o_phase        (n_phase),
        .o_last_pressed (n_last_pressed),
        .o_change_time  (n_change_time),
        .o_press_start  (n_press_start),
        .o_result       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= bdpr_pkg::DEBOUNCE_RESET;
            r_pressed_level <= bdpr_pkg::PRESSED_LEVEL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bdpr_pkg::CFG_DEBOUNCE_MS: begin
                    r_debounce_ms <= i_cfg_data;
                end
                bdpr_pkg::CFG_PRESSED_LEVEL: begin
                    r_pressed_level <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
            r_phase        <= bdpr_pkg::PH_AWAIT_PRESS;
            r_last_pressed <= 1'b0;
            r_change_time  <= '0;
            r_press_start  <= '0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld      <= 1'b1;
                r_phase        <= n_phase;
                r_last_pressed <= n_last_pressed;
                r_change_time  <= n_change_time;
                r_press_start  <= n_press_start;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.press_event && r_out.release_event))
        else $error("press and release offered in the same result");

    a_held_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.release_event) |-> (r_out.held_ms == '0))
        else $error("held time reported without a release");

    a_pressing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.button_down) |-> (r_out.pressing_ms == '0))
        else $error("pressing time reported while the button is up");

    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !out_free) |=> (r_in_vld && $stable(r_in)))
        else $error("waiting poll lost from the input register");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the debounced button press and release block.
module tb;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned MAX_REPORTS  = 40;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_cfg_we   = 1'b0;
    logic [bdpr_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [bdpr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    bdpr_pkg::t_in_item              i_in_data  = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    bdpr_pkg::t_out_item             o_out_data;

    // Expected register contents and button state, kept alongside the block.
    logic [bdpr_pkg::DEBOUNCE_W-1:0]   debounce_cfg     = bdpr_pkg::DEBOUNCE_RESET;
    logic                              level_cfg        = bdpr_pkg::PRESSED_LEVEL_RESET;
    bdpr_pkg::t_phase                  btn_phase        = bdpr_pkg::PH_AWAIT_PRESS;
    logic                              btn_last_pressed = 1'b0;
    logic [bdpr_pkg::FIELD_TIME_W-1:0] btn_change_ms    = '0;
    logic [bdpr_pkg::FIELD_TIME_W-1:0] btn_press_ms     = '0;

    bdpr_pkg::t_out_item pending_results[$];
    bdpr_pkg::t_out_item expected_result;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_cycles   = 0;
    int accept_pct    = 70;

    logic [bdpr_pkg::FIELD_TIME_W-1:0] poll_ms        = '0;
    logic                              intended_level = 1'b1;
    int                                bounce_left    = 0;

    int          errors         = 0;
    int          polls_sent     = 0;
    int          results_seen   = 0;
    int          presses_seen   = 0;
    int          releases_seen  = 0;
    int          reg_writes     = 0;
    int unsigned cycle_count    = 0;

    button_debounce_press_release_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bdpr_pkg::t_out_item debounce_step(input bdpr_pkg::t_in_item poll);
        bdpr_pkg::t_out_item               res;
        bdpr_pkg::t_phase                  nxt;
        logic                              pressed;
        logic [bdpr_pkg::FIELD_TIME_W-1:0] since_change;
        res          = '0;
        pressed      = (poll.pin_level == level_cfg);
        since_change = poll.now_ms - btn_change_ms;
        if (pressed != btn_last_pressed) begin
            btn_change_ms    = poll.now_ms;
            btn_last_pressed = pressed;
        end else if (since_change >= bdpr_pkg::FIELD_TIME_W'(debounce_cfg)) begin
            nxt = btn_phase;
            if (nxt == bdpr_pkg::PH_AWAIT_PRESS && pressed) begin
                nxt          = bdpr_pkg::PH_PRESSED;
                btn_press_ms = poll.now_ms;
            end
            if (nxt == bdpr_pkg::PH_PRESSED) begin
                if (!pressed) begin
                    nxt = bdpr_pkg::PH_RELEASED;
                end else begin
                    res.press_event = 1'b1;
                    if (poll.press_accept) nxt = bdpr_pkg::PH_AWAIT_RELEASE;
                end
            end else begin
                if (nxt == bdpr_pkg::PH_AWAIT_RELEASE && !pressed) nxt = bdpr_pkg::PH_RELEASED;
                if (nxt == bdpr_pkg::PH_RELEASED && btn_phase != bdpr_pkg::PH_PRESSED) begin
                    res.release_event = 1'b1;
                    res.held_ms       = poll.now_ms - btn_press_ms;
                    if (poll.release_accept) nxt = bdpr_pkg::PH_AWAIT_PRESS;
                end
            end
            btn_phase = nxt;
        end
        res.button_down = (btn_phase != bdpr_pkg::PH_AWAIT_PRESS);
        if (res.button_down) res.pressing_ms = poll.now_ms - btn_press_ms;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("mismatch on result %0d: %s got %h expected %h",
                     results_seen, what, got, want);
        end
    endtask

    // Result checker: every transfer on the output side is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(o_out_data.press_event), 0);
            end else begin
                expected_result = pending_results.pop_front();
                if (expected_result.press_event) presses_seen++;
                if (expected_result.release_event) releases_seen++;
                if (o_out_data.press_event !== expected_result.press_event)
                    report_mismatch("press_event", 32'(o_out_data.press_event),
                                    32'(expected_result.press_event));
                if (o_out_data.release_event !== expected_result.release_event)
                    report_mismatch("release_event", 32'(o_out_data.release_event),
                                    32'(expected_result.release_event));
                if (o_out_data.held_ms !== expected_result.held_ms)
                    report_mismatch("held_ms", o_out_data.held_ms, expected_result.held_ms);
                if (o_out_data.button_down !== expected_result.button_down)
                    report_mismatch("button_down", 32'(o_out_data.button_down),
                                    32'(expected_result.button_down));
                if (o_out_data.pressing_ms !== expected_result.pressing_ms)
                    report_mismatch("pressing_ms", o_out_data.pressing_ms,
                                    expected_result.pressing_ms);
            end
        end
    end

    // Receiver: a requested hold-off first, otherwise random stalls.
    always begin
        @(negedge i_clk);
        if (hold_cycles > 0) begin
            i_out_stall = 1'b1;
            hold_cycles--;
        end else begin
            i_out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results pending",
                 cycle_count, pending_results.size());
        $display("FAIL");
        $finish;
    end

    task automatic send_poll(input bdpr_pkg::t_in_item poll);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_data  = poll;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(debounce_step(poll));
        polls_sent++;
        @(negedge i_clk);
    endtask

    task automatic drive_poll(input logic level,
                              input logic [bdpr_pkg::FIELD_TIME_W-1:0] now,
                              input logic pacc, input logic racc);
        bdpr_pkg::t_in_item poll;
        poll.pin_level      = level;
        poll.now_ms         = now;
        poll.press_accept   = pacc;
        poll.release_accept = racc;
        send_poll(poll);
    endtask

    task automatic wait_for_results();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_register(input logic [bdpr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [bdpr_pkg::CFG_DATA_W-1:0] value);
        wait_for_results();
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            bdpr_pkg::CFG_DEBOUNCE_MS:   debounce_cfg = value[bdpr_pkg::DEBOUNCE_W-1:0];
            bdpr_pkg::CFG_PRESSED_LEVEL: level_cfg    = value[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic configure(input logic [bdpr_pkg::DEBOUNCE_W-1:0] debounce,
                             input logic level);
        set_register(bdpr_pkg::CFG_DEBOUNCE_MS, bdpr_pkg::CFG_DATA_W'(debounce));
        set_register(bdpr_pkg::CFG_PRESSED_LEVEL,
                     {(bdpr_pkg::CFG_DATA_W-1)'($urandom), level});
    endtask

    // Mostly clean presses and releases with contact bounce, plus occasional stray polls.
    task automatic random_polls(input int count);
        bdpr_pkg::t_in_item poll;
        int unsigned        step_max;
        repeat (count) begin
            step_max            = debounce_cfg / 3 + 2;
            poll.press_accept   = ($urandom_range(99) < accept_pct);
            poll.release_accept = ($urandom_range(99) < accept_pct);
            if ($urandom_range(99) < 6) begin
                poll.pin_level = 1'($urandom_range(1));
                poll.now_ms    = $urandom;
            end else begin
                if (bounce_left == 0 && $urandom_range(99) < 10) begin
                    intended_level = !intended_level;
                    bounce_left    = $urandom_range(4);
                end
                if (bounce_left > 0) begin
                    bounce_left--;
                    poll.pin_level = 1'($urandom_range(1));
                    poll_ms += $urandom_range(step_max / 4);
                end else begin
                    poll.pin_level = intended_level;
                    poll_ms += $urandom_range(step_max);
                end
                poll.now_ms = poll_ms;
            end
            send_poll(poll);
        end
    endtask

    task automatic test_reset_defaults();
        drive_poll(1'b1, 32'd0, 1'b1, 1'b1);
        drive_poll(1'b1, 32'd50, 1'b1, 1'b1);
        drive_poll(1'b0, 32'd60, 1'b1, 1'b1);
        drive_poll(1'b0, 32'd70, 1'b1, 1'b1);
        drive_poll(1'b0, 32'd110, 1'b0, 1'b1);
        drive_poll(1'b0, 32'd120, 1'b0, 1'b1);
        drive_poll(1'b1, 32'd130, 1'b0, 1'b0);
        drive_poll(1'b1, 32'd180, 1'b0, 1'b0);
        drive_poll(1'b1, 32'd190, 1'b0, 1'b0);
        drive_poll(1'b1, 32'd200, 1'b0, 1'b1);
        drive_poll(1'b0, 32'd210, 1'b0, 1'b0);
        drive_poll(1'b0, 32'd260, 1'b1, 1'b0);
        drive_poll(1'b0, 32'd300, 1'b0, 1'b0);
        drive_poll(1'b1, 32'd310, 1'b0, 1'b0);
        drive_poll(1'b1, 32'd360, 1'b0, 1'b1);
        drive_poll(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
        drive_poll(1'b0, 32'hFFFF_FFC0, 1'b1, 1'b1);
        drive_poll(1'b0, 32'hFFFF_FFF8, 1'b1, 1'b1);
        drive_poll(1'b1, 32'h0000_0010, 1'b1, 1'b1);
        drive_poll(1'b1, 32'h0000_0050, 1'b1, 1'b1);
        drive_poll(1'b1, 32'h0000_0000, 1'b0, 1'b0);
    endtask

    task automatic test_zero_debounce();
        configure(16'd0, 1'b1);
        drive_poll(1'b0, 32'd1000, 1'b1, 1'b1);
        drive_poll(1'b0, 32'd1000, 1'b1, 1'b1);
        drive_poll(1'b1, 32'd1000, 1'b1, 1'b1);
        drive_poll(1'b1, 32'd1000, 1'b1, 1'b1);
        drive_poll(1'b0, 32'd1001, 1'b1, 1'b1);
        drive_poll(1'b0, 32'd1001, 1'b1, 1'b1);
        poll_ms = 32'd2000;
        random_polls(150);
    endtask

    task automatic test_sender_gaps();
        configure(16'd5, 1'b0);
        send_idle_pct = 67;
        random_polls(350);
        send_idle_pct = 0;
    endtask

    task automatic test_receiver_stalls();
        configure(16'd20, 1'b1);
        stall_pct = 67;
        random_polls(350);
        stall_pct = 0;
    endtask

    task automatic test_both_idle();
        configure(16'd1, 1'b0);
        send_idle_pct = 13;
        stall_pct     = 13;
        random_polls(350);
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    task automatic test_long_debounce_wrap();
        configure(16'hFFFF, 1'b1);
        poll_ms    = 32'hFFFF_0000;
        accept_pct = 30;
        random_polls(200);
        accept_pct = 70;
    endtask

    task automatic test_backpressure();
        configure(16'd3, 1'b0);
        hold_cycles = 80;
        random_polls(60);
        wait_for_results();
        hold_cycles = 50;
        random_polls(40);
        wait_for_results();
    endtask

    task automatic test_mixed_settings();
        int round;
        for (round = 0; round < 6; round++) begin
            if ($urandom_range(3) == 0) begin
                configure(bdpr_pkg::DEBOUNCE_W'($urandom), 1'($urandom_range(1)));
            end else begin
                configure(bdpr_pkg::DEBOUNCE_W'($urandom_range(40)), 1'($urandom_range(1)));
            end
            case (round % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 67; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 67; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            random_polls(50);
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_zero_debounce();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_long_debounce_wrap();
        test_backpressure();
        test_mixed_settings();
        wait_for_results();
        $display("Sent %0d polls and checked %0d results over %0d register writes.",
                 polls_sent, results_seen, reg_writes);
        $display("Results held %0d press offers and %0d release offers; %0d mismatches.",
                 presses_seen, releases_seen, errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/bdpr_pkg.sv
hw/rtl/bdpr_step.sv
hw/rtl/button_debounce_press_release_top.sv
tb/tb.sv
